/* rtl/core/rvx_pkg.sv */
// Shared constants, codes and types of the RV32I execute unit.
package rvx_pkg;

  localparam int DATA_BYTES = 65536;
  localparam int ADDR_W     = $clog2(DATA_BYTES);
  localparam int ROW_W      = ADDR_W - 2;
  localparam int ROWS       = DATA_BYTES / 4;

  localparam logic [31:0] CONSOLE_RST = 32'h0000_5000;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  localparam logic       CMD_EXEC    = 1'b0;
  localparam logic       CMD_PRELOAD = 1'b1;

  typedef struct packed {
    logic        ill;
    logic        wr;
    logic [31:0] val;
    logic [31:0] npc;
    logic        ld;
    logic        st;
    logic [31:0] ea;
    logic [2:0]  nbytes;
  } exe_t;

endpackage

/* rtl/core/rvx_ram.sv */
// Generic single write port RAM with registered read.
module rvx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rvx_alu.sv */
// Instruction decode, ALU, branch and address logic for one instruction.
module rvx_alu (
  input  logic [31:0]      ins,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  input  logic [31:0]      pc,
  output rvx_pkg::exe_t    res
);

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi, imms, immb, immj, immu, src, pc4;
  logic [4:0]  sh;
  logic        take;

  assign op   = ins[6:0];
  assign f3   = ins[14:12];
  assign f7   = ins[31:25];
  assign immi = {{20{ins[31]}}, ins[31:20]};
  assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign immu = {ins[31:12], 12'h000};
  assign pc4  = pc + 32'd4;
  assign src  = (op == rvx_pkg::OP_REG) ? b : immi;
  assign sh   = src[4:0];

  always_comb begin
    res        = '0;
    res.npc    = pc4;
    take       = 1'b0;
    case (op)
      rvx_pkg::OP_REG, rvx_pkg::OP_IMM: begin
        res.wr = 1'b1;
        case (f3)
          rvx_pkg::F3_ADD: begin
            if (op == rvx_pkg::OP_IMM || f7 == rvx_pkg::F7_BASE) begin
              res.val = a + src;
            end else if (f7 == rvx_pkg::F7_ALT) begin
              res.val = a - src;
            end else begin
              res.ill = 1'b1;
            end
          end
          rvx_pkg::F3_SLL:  res.val = a << sh;
          rvx_pkg::F3_SLT:  res.val = {31'b0, $signed(a) < $signed(src)};
          rvx_pkg::F3_SLTU: res.val = {31'b0, a < src};
          rvx_pkg::F3_XOR:  res.val = a ^ src;
          rvx_pkg::F3_SR: begin
            if (f7 == rvx_pkg::F7_BASE) begin
              res.val = a >> sh;
            end else if (f7 == rvx_pkg::F7_ALT) begin
              res.val = $unsigned($signed(a) >>> sh);
            end else begin
              res.ill = 1'b1;
            end
          end
          rvx_pkg::F3_OR:   res.val = a | src;
          default:          res.val = a & src;
        endcase
      end
      rvx_pkg::OP_BRANCH: begin
        case (f3)
          rvx_pkg::F3_BEQ:  take = (a == b);
          rvx_pkg::F3_BNE:  take = (a != b);
          rvx_pkg::F3_BLT:  take = $signed(a) < $signed(b);
          rvx_pkg::F3_BGE:  take = $signed(a) >= $signed(b);
          rvx_pkg::F3_BLTU: take = a < b;
          rvx_pkg::F3_BGEU: take = a >= b;
          default:          res.ill = 1'b1;
        endcase
        if (take) begin
          res.npc = pc + immb;
        end
      end
      rvx_pkg::OP_JAL: begin
        res.wr  = 1'b1;
        res.val = pc4;
        res.npc = pc + immj;
      end
      rvx_pkg::OP_JALR: begin
        res.wr  = 1'b1;
        res.val = pc4;
        res.npc = (a + immi) & 32'hFFFF_FFFE;
      end
      rvx_pkg::OP_STORE: begin
        res.ea = a + imms;
        case (f3)
          rvx_pkg::F3_B: res.nbytes = 3'd1;
          rvx_pkg::F3_H: res.nbytes = 3'd2;
          rvx_pkg::F3_W: res.nbytes = 3'd4;
          default:       res.ill    = 1'b1;
        endcase
        res.st = 1'b1;
      end
      rvx_pkg::OP_LOAD: begin
        res.ea = a + immi;
        res.wr = 1'b1;
        res.ld = 1'b1;
        case (f3)
          rvx_pkg::F3_B, rvx_pkg::F3_H, rvx_pkg::F3_W,
          rvx_pkg::F3_BU, rvx_pkg::F3_HU: res.ill = 1'b0;
          default:                        res.ill = 1'b1;
        endcase
      end
      rvx_pkg::OP_LUI: begin
        res.wr  = 1'b1;
        res.val = immu;
      end
      rvx_pkg::OP_AUIPC: begin
        res.wr  = 1'b1;
        res.val = pc + immu;
      end
      default: res.ill = 1'b1;
    endcase
    if (res.ill) begin
      res.npc = pc;
      res.wr  = 1'b0;
      res.ld  = 1'b0;
      res.st  = 1'b0;
      res.val = '0;
    end
  end

endmodule

/* rtl/core/rv32i_instruction_execute_unit.sv */
// Top level of the RV32I execute unit: operand fetch, execute, load return, result.
//
//  channel | direction | ports
//  in_     | in        | in_valid, in_ready, in_cmd, in_instruction, in_preload_*
//  out_    | out       | out_valid, out_ready, out_next_pc .. out_console_char
//  cfg_    | in        | cfg_valid, cfg_ready, cfg_data (console address)
//
// Non-load items finish in execute: one item per cycle sustained while results are taken.
// Loads go on to load return for the registered data memory read (4 byte banks).
// The register file is two registered-read RAMs; a write landing on the accept
// edge is forwarded. Reset (rst_n low, synchronous) zeroes pc and registers.
// A full result register that is not taken stalls execute and then the input.
module rv32i_instruction_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_instruction,
  input  logic [15:0] in_preload_address,
  input  logic [7:0]  in_preload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_pc,
  output logic        out_illegal,
  output logic        out_rd_write_valid,
  output logic [4:0]  out_rd_index,
  output logic [31:0] out_rd_value,
  output logic        out_console_valid,
  output logic [7:0]  out_console_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = rvx_pkg::ADDR_W;
  localparam int RW = rvx_pkg::ROW_W;

  logic [31:0] console_r;
  logic [31:0] pc_r, pc_nxt;
  logic        ex_v_r, mem_v_r, out_v_r;
  logic        cmd_r;
  logic [31:0] ins_r;
  logic [AW-1:0] pa_r;
  logic [7:0]  pb_r;
  logic [31:0] rf_vld_r;
  logic        vld1_r, vld2_r, byp1_r, byp2_r;
  logic [31:0] bval1_r, bval2_r;
  logic [31:0] ram1, ram2, a, b;
  rvx_pkg::exe_t e;

  logic        oslot, fin_e, fin_m, mv_m, accept;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;

  logic [4:0]  m_rd_r;
  logic [2:0]  m_f3_r;
  logic [1:0]  m_lo_r;
  logic [31:0] m_npc_r;

  logic [31:0] o_npc_r, o_val_r;
  logic        o_ill_r, o_wr_r, o_con_r;
  logic [4:0]  o_rd_r;
  logic [7:0]  o_ch_r;

  logic [7:0]  bank_rd [4];
  logic [7:0]  lb [4];
  logic [31:0] ld_val;
  logic [AW-1:0] pa_in;
  logic [4:0]  rd_e;
  logic        wr_e;

  assign cfg_ready = 1'b1;
  assign oslot     = !out_v_r || out_ready;
  assign fin_e     = ex_v_r && !(cmd_r == rvx_pkg::CMD_EXEC && e.ld) && oslot;
  assign mv_m      = ex_v_r && cmd_r == rvx_pkg::CMD_EXEC && e.ld;
  assign fin_m     = mem_v_r && oslot;
  assign in_ready  = (!ex_v_r || fin_e) && (!mem_v_r || fin_m);
  assign accept    = in_valid && in_ready;
  assign pa_in     = AW'({16'b0, in_preload_address});
  assign rd_e      = ins_r[11:7];
  assign wr_e      = cmd_r == rvx_pkg::CMD_EXEC && e.wr && rd_e != 5'd0;

  assign a = byp1_r ? bval1_r : (vld1_r ? ram1 : 32'd0);
  assign b = byp2_r ? bval2_r : (vld2_r ? ram2 : 32'd0);

  rvx_alu u_alu (
    .ins (ins_r),
    .a   (a),
    .b   (b),
    .pc  (pc_r),
    .res (e)
  );

  // register file write: execute finish or load return
  always_comb begin
    rf_we = 1'b0;
    rf_wa = m_rd_r;
    rf_wd = ld_val;
    if (fin_m) begin
      rf_we = m_rd_r != 5'd0;
    end else if (fin_e && wr_e) begin
      rf_we = 1'b1;
      rf_wa = rd_e;
      rf_wd = e.val;
    end
  end

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .re(accept), .raddr(in_instruction[19:15]), .rdata(ram1)
  );

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .re(accept), .raddr(in_instruction[24:20]), .rdata(ram2)
  );

  // data memory: four byte banks interleaved on address bits [1:0]
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [1:0]    k;
    logic [RW-1:0] row;
    logic          bwe, bre;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;

    assign k   = 2'(j) - e.ea[1:0];
    assign row = e.ea[AW-1:2] + RW'(2'(j) < e.ea[1:0]);
    assign bre = mv_m && !mem_v_r;

    always_comb begin
      bwe   = 1'b0;
      waddr = row;
      wdata = b[8*k +: 8];
      if (fin_e && cmd_r == rvx_pkg::CMD_PRELOAD) begin
        bwe   = pa_r[1:0] == 2'(j);
        waddr = pa_r[AW-1:2];
        wdata = pb_r;
      end else if (fin_e && e.st) begin
        bwe   = {1'b0, k} < e.nbytes;
      end
    end

    rvx_ram #(.WIDTH(8), .DEPTH(rvx_pkg::ROWS)) u_bank (
      .clk(clk), .we(bwe), .waddr(waddr), .wdata(wdata),
      .re(bre), .raddr(row), .rdata(bank_rd[j])
    );
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lb[i] = bank_rd[2'(m_lo_r + 2'(i))];
    end
    case (m_f3_r)
      rvx_pkg::F3_B:  ld_val = {{24{lb[0][7]}}, lb[0]};
      rvx_pkg::F3_H:  ld_val = {{16{lb[1][7]}}, lb[1], lb[0]};
      rvx_pkg::F3_W:  ld_val = {lb[3], lb[2], lb[1], lb[0]};
      rvx_pkg::F3_BU: ld_val = {24'b0, lb[0]};
      default:        ld_val = {16'b0, lb[1], lb[0]};
    endcase
    if (m_rd_r == 5'd0) begin
      ld_val = '0;
    end
  end

  always_comb begin
    pc_nxt = pc_r;
    if ((fin_e || mv_m) && cmd_r == rvx_pkg::CMD_EXEC) begin
      pc_nxt = e.npc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      console_r <= rvx_pkg::CONSOLE_RST;
      pc_r      <= '0;
      ex_v_r    <= 1'b0;
      mem_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
      rf_vld_r  <= '0;
    end else begin
      if (cfg_valid) begin
        console_r <= cfg_data;
      end
      pc_r <= pc_nxt;
      if (rf_we) begin
        rf_vld_r[rf_wa] <= 1'b1;
      end
      if (accept) begin
        ex_v_r <= 1'b1;
      end else if (fin_e || mv_m) begin
        ex_v_r <= 1'b0;
      end
      if (mv_m) begin
        mem_v_r <= 1'b1;
      end else if (fin_m) begin
        mem_v_r <= 1'b0;
      end
      if (fin_e || fin_m) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      ins_r   <= in_instruction;
      pa_r    <= pa_in;
      pb_r    <= in_preload_byte;
      vld1_r  <= rf_vld_r[in_instruction[19:15]];
      vld2_r  <= rf_vld_r[in_instruction[24:20]];
      byp1_r  <= rf_we && rf_wa == in_instruction[19:15];
      byp2_r  <= rf_we && rf_wa == in_instruction[24:20];
      bval1_r <= rf_wd;
      bval2_r <= rf_wd;
    end
    if (mv_m) begin
      m_rd_r  <= rd_e;
      m_f3_r  <= ins_r[14:12];
      m_lo_r  <= e.ea[1:0];
      m_npc_r <= e.npc;
    end
    if (fin_m) begin
      o_npc_r <= m_npc_r;
      o_ill_r <= 1'b0;
      o_wr_r  <= m_rd_r != 5'd0;
      o_rd_r  <= m_rd_r;
      o_val_r <= ld_val;
      o_con_r <= 1'b0;
      o_ch_r  <= '0;
    end else if (fin_e) begin
      if (cmd_r == rvx_pkg::CMD_PRELOAD) begin
        o_npc_r <= pc_r;
        o_ill_r <= 1'b0;
        o_wr_r  <= 1'b0;
        o_rd_r  <= '0;
        o_val_r <= '0;
        o_con_r <= 1'b0;
        o_ch_r  <= '0;
      end else begin
        o_npc_r <= e.npc;
        o_ill_r <= e.ill;
        o_wr_r  <= wr_e;
        o_rd_r  <= wr_e ? rd_e : 5'd0;
        o_val_r <= wr_e ? e.val : 32'd0;
        o_con_r <= e.st && e.nbytes == 3'd1 && e.ea == console_r;
        o_ch_r  <= (e.st && e.nbytes == 3'd1 && e.ea == console_r) ? b[7:0] : 8'd0;
      end
    end
  end

  assign out_valid          = out_v_r;
  assign out_next_pc        = o_npc_r;
  assign out_illegal        = o_ill_r;
  assign out_rd_write_valid = o_wr_r;
  assign out_rd_index       = o_rd_r;
  assign out_rd_value       = o_val_r;
  assign out_console_valid  = o_con_r;
  assign out_console_char   = o_ch_r;

`ifndef SYNTHESIS
  a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !(ex_v_r && mem_v_r))
    else $error("execute and load return both occupied");
  a_no_accept_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    mv_m |-> !in_ready)
    else $error("input accepted while a load leaves execute");
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> rf_wa != 5'd0)
    else $error("write to x0");
  a_ill_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_ill_r |-> !o_wr_r && !o_con_r)
    else $error("illegal result carries a write");
`endif

endmodule

/* verif/rv32i_instruction_execute_unit_tb.sv */
// Self-checking testbench of the RV32I execute unit: directed and random instruction streams vs. a shadow core.
`timescale 1ns / 1ps
module rv32i_instruction_execute_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 180;
  localparam logic [6:0] OP_UNKNOWN = 7'h0B;

  typedef struct packed {
    logic        cmd;
    logic [31:0] instruction;
    logic [15:0] paddr;
    logic [7:0]  pbyte;
  } instr_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        illegal;
    logic        rd_wr;
    logic [4:0]  rd_idx;
    logic [31:0] rd_val;
    logic        con_valid;
    logic [7:0]  con_char;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = 1'b0;
  logic [31:0] in_instruction = '0;
  logic [15:0] in_preload_address = '0;
  logic [7:0]  in_preload_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_next_pc;
  logic        out_illegal;
  logic        out_rd_write_valid;
  logic [4:0]  out_rd_index;
  logic [31:0] out_rd_value;
  logic        out_console_valid;
  logic [7:0]  out_console_char;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  rv32i_instruction_execute_unit u_dut (.*);

  // shadow architectural state
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic [7:0]  dmem [rvx_pkg::DATA_BYTES];
  bit          dmem_set [rvx_pkg::DATA_BYTES];
  int          dmem_set_list [$];
  logic [31:0] console_addr;

  instr_item_t instr_q [$];
  retire_t     retire_q [$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          in_calm = 0, out_calm = 0;
  int          in_gap = 0, out_gap = 0;

  initial forever #5 clk = ~clk;

  function automatic int pick_gap(bit calm);
    int k;
    k = $urandom_range(0, 99);
    if (calm || k < 45) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int mem_idx(logic [31:0] ea, int k);
    return int'((ea % rvx_pkg::DATA_BYTES + k) % rvx_pkg::DATA_BYTES);
  endfunction

  function automatic bit bytes_set(logic [31:0] ea, int n);
    for (int k = 0; k < n; k++)
      if (!dmem_set[mem_idx(ea, k)]) return 0;
    return 1;
  endfunction

  task automatic mark_byte(int idx, logic [7:0] v);
    dmem[idx] = v;
    if (!dmem_set[idx]) begin
      dmem_set[idx] = 1;
      dmem_set_list.push_back(idx);
    end
  endtask

  function automatic logic [31:0] dmem_rd(logic [31:0] ea, int n);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v[8*k +: 8] = dmem[mem_idx(ea, k)];
    return v;
  endfunction

  // executes one item on the shadow state
  task automatic retire_instr(input instr_item_t s, output retire_t r);
    logic [31:0] ins, a, b, pc, npc, immi, imms, immb, immj, val, ea, src;
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        ill, wr, con, take;
    logic [7:0]  ch;
    ins = s.instruction;
    op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
    a = arch_regs[ins[19:15]]; b = arch_regs[ins[24:20]];
    pc = arch_pc; npc = pc + 32'd4;
    immi = {{20{ins[31]}}, ins[31:20]};
    imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    ill = 0; wr = 0; con = 0; take = 0; val = '0; ch = '0;
    if (s.cmd == rvx_pkg::CMD_PRELOAD) begin
      mark_byte(int'(s.paddr % rvx_pkg::DATA_BYTES), s.pbyte);
      npc = pc;
    end else begin
      case (op)
        rvx_pkg::OP_REG, rvx_pkg::OP_IMM: begin
          src = (op == rvx_pkg::OP_REG) ? b : immi;
          wr = 1;
          case (f3)
            rvx_pkg::F3_ADD:
              if (op == rvx_pkg::OP_IMM || f7 == rvx_pkg::F7_BASE) val = a + src;
              else if (f7 == rvx_pkg::F7_ALT) val = a - src;
              else ill = 1;
            rvx_pkg::F3_SLL:  val = a << src[4:0];
            rvx_pkg::F3_SLT:  val = {31'b0, $signed(a) < $signed(src)};
            rvx_pkg::F3_SLTU: val = {31'b0, a < src};
            rvx_pkg::F3_XOR:  val = a ^ src;
            rvx_pkg::F3_SR:
              if (f7 == rvx_pkg::F7_BASE) val = a >> src[4:0];
              else if (f7 == rvx_pkg::F7_ALT) val = $signed(a) >>> src[4:0];
              else ill = 1;
            rvx_pkg::F3_OR:   val = a | src;
            default:          val = a & src;
          endcase
        end
        rvx_pkg::OP_BRANCH: begin
          case (f3)
            rvx_pkg::F3_BEQ:  take = (a == b);
            rvx_pkg::F3_BNE:  take = (a != b);
            rvx_pkg::F3_BLT:  take = $signed(a) < $signed(b);
            rvx_pkg::F3_BGE:  take = $signed(a) >= $signed(b);
            rvx_pkg::F3_BLTU: take = a < b;
            rvx_pkg::F3_BGEU: take = a >= b;
            default:          ill = 1;
          endcase
          if (take) npc = pc + immb;
        end
        rvx_pkg::OP_JAL: begin
          wr = 1; val = pc + 32'd4; npc = pc + immj;
        end
        rvx_pkg::OP_JALR: begin
          wr = 1; val = pc + 32'd4; npc = (a + immi) & ~32'd1;
        end
        rvx_pkg::OP_STORE: begin
          ea = a + imms;
          if (f3 > rvx_pkg::F3_W) ill = 1;
          else begin
            for (int k = 0; k < (1 << f3); k++) mark_byte(mem_idx(ea, k), b[8*k +: 8]);
            if (f3 == rvx_pkg::F3_B && ea == console_addr) begin
              con = 1; ch = b[7:0];
            end
          end
        end
        rvx_pkg::OP_LOAD: begin
          ea = a + immi;
          wr = 1;
          case (f3)
            rvx_pkg::F3_B: begin
              val = dmem_rd(ea, 1);
              val = {{24{val[7]}}, val[7:0]};
            end
            rvx_pkg::F3_H: begin
              val = dmem_rd(ea, 2);
              val = {{16{val[15]}}, val[15:0]};
            end
            rvx_pkg::F3_W:  val = dmem_rd(ea, 4);
            rvx_pkg::F3_BU: val = dmem_rd(ea, 1);
            rvx_pkg::F3_HU: val = dmem_rd(ea, 2);
            default:        ill = 1;
          endcase
        end
        rvx_pkg::OP_LUI:   begin wr = 1; val = {ins[31:12], 12'b0}; end
        rvx_pkg::OP_AUIPC: begin wr = 1; val = pc + {ins[31:12], 12'b0}; end
        default:           ill = 1;
      endcase
      if (ill) begin
        npc = pc; wr = 0;
      end
      if (wr && rd != 5'd0) arch_regs[rd] = val;
      else wr = 0;
      arch_pc = npc;
    end
    if (!wr) begin
      val = '0; rd = '0;
    end
    r = '{npc, ill, wr, rd, val, con, ch};
  endtask

  task automatic issue(input instr_item_t s);
    retire_t r;
    retire_instr(s, r);
    retire_q.push_back(r);
    instr_q.push_back(s);
  endtask

  task automatic issue_ins(input logic [31:0] ins);
    issue('{rvx_pkg::CMD_EXEC, ins, 16'($urandom), 8'($urandom)});
  endtask

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvx_pkg::OP_BRANCH};
  endfunction

  function automatic logic [4:0] rnd_reg();
    return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(1, 7)) : 5'($urandom);
  endfunction

  function automatic int load_bytes(logic [2:0] f3);
    return (f3 == rvx_pkg::F3_W) ? 4 :
           (f3 == rvx_pkg::F3_H || f3 == rvx_pkg::F3_HU) ? 2 : 1;
  endfunction

  // preload window that x0-based accesses reach
  function automatic logic [15:0] window_addr();
    return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2047))
                                       : 16'($urandom_range(63488, 65535));
  endfunction

  task automatic gen_load();
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [11:0] imm;
    logic [31:0] delta;
    int          w;
    bit          found;
    f3 = (($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                      : 3'($urandom_range(0, 5)));
    if (f3 == 3'd3 || f3 >= 3'd6) begin
      issue_ins(enc_i(12'($urandom), rnd_reg(), f3, rnd_reg(), rvx_pkg::OP_LOAD));
      return;
    end
    found = 0;
    for (int t = 0; t < 8 && !found; t++) begin
      rs1 = ($urandom_range(0, 2) == 0) ? 5'd0 : rnd_reg();
      if ($urandom_range(0, 1) == 0 && dmem_set_list.size() > 0) begin
        w = dmem_set_list[$urandom_range(0, dmem_set_list.size() - 1)];
        delta = 32'(w) - arch_regs[rs1];
        imm = delta[11:0];
      end else begin
        imm = 12'($urandom);
      end
      found = bytes_set(arch_regs[rs1] + {{20{imm[11]}}, imm}, load_bytes(f3));
    end
    if (!found) begin
      rs1 = 5'd0; imm = '0; f3 = rvx_pkg::F3_BU;
    end
    issue_ins(enc_i(imm, rs1, f3, rnd_reg(), rvx_pkg::OP_LOAD));
  endtask

  task automatic gen_console_store();
    logic [31:0] up, lo;
    up = (console_addr + 32'h800) & 32'hFFFF_F000;
    lo = console_addr - up;
    issue_ins({up[31:12], 5'd5, rvx_pkg::OP_LUI});
    issue_ins(enc_s(lo[11:0], rnd_reg(), 5'd5, rvx_pkg::F3_B));
  endtask

  task automatic gen_one();
    int          k;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [31:0] ins, ea;
    k = $urandom_range(0, 99);
    f7 = ($urandom_range(0, 9) == 0) ? 7'($urandom)
         : (($urandom_range(0, 1) == 0) ? rvx_pkg::F7_BASE : rvx_pkg::F7_ALT);
    if (k < 8) begin
      issue('{rvx_pkg::CMD_PRELOAD, 32'($urandom),
              ($urandom_range(0, 3) == 0) ? 16'($urandom) : window_addr(), 8'($urandom)});
    end else if (k < 28) begin
      issue_ins(enc_r(f7, rnd_reg(), rnd_reg(), 3'($urandom), rnd_reg(), rvx_pkg::OP_REG));
    end else if (k < 48) begin
      f3 = 3'($urandom);
      ins = enc_i(12'($urandom), rnd_reg(), f3, rnd_reg(), rvx_pkg::OP_IMM);
      if (f3 == rvx_pkg::F3_SR) ins[31:25] = f7;
      issue_ins(ins);
    end else if (k < 52) begin
      issue_ins({20'($urandom), rnd_reg(), rvx_pkg::OP_LUI});
    end else if (k < 55) begin
      issue_ins({20'($urandom), rnd_reg(), rvx_pkg::OP_AUIPC});
    end else if (k < 59) begin
      issue_ins({20'($urandom), rnd_reg(), rvx_pkg::OP_JAL});
    end else if (k < 63) begin
      issue_ins(enc_i(12'($urandom), rnd_reg(), 3'($urandom), rnd_reg(), rvx_pkg::OP_JALR));
    end else if (k < 73) begin
      issue_ins(enc_b(13'($urandom), rnd_reg(), rnd_reg(), 3'($urandom)));
    end else if (k < 83) begin
      f3 = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
      issue_ins(enc_s({1'b0, window_addr()} < 2048 ? 12'($urandom) : 12'($urandom),
                      rnd_reg(), ($urandom_range(0, 1) == 0) ? 5'd0 : rnd_reg(), f3));
    end else if (k < 93) begin
      gen_load();
    end else if (k < 96) begin
      gen_console_store();
    end else begin
      ins = $urandom;
      ea = arch_regs[ins[19:15]] + {{20{ins[31]}}, ins[31:20]};
      // a legal load from never-written bytes is turned into an unknown opcode
      if (ins[6:0] == rvx_pkg::OP_LOAD &&
          (ins[14:12] <= rvx_pkg::F3_W || ins[14:12] == rvx_pkg::F3_BU ||
           ins[14:12] == rvx_pkg::F3_HU) && !bytes_set(ea, load_bytes(ins[14:12])))
        ins[6:0] = OP_UNKNOWN;
      issue_ins(ins);
    end
  endtask

  task automatic directed_items();
    issue('{rvx_pkg::CMD_PRELOAD, 32'h0, 16'h0000, 8'hFF});
    issue('{rvx_pkg::CMD_PRELOAD, 32'hFFFF_FFFF, 16'h0001, 8'h80});
    issue('{rvx_pkg::CMD_PRELOAD, 32'h0, 16'h0002, 8'h34});
    issue('{rvx_pkg::CMD_PRELOAD, 32'h0, 16'h0003, 8'hA5});
    issue('{rvx_pkg::CMD_PRELOAD, 32'h0, 16'hFFFF, 8'h00});
    issue('{rvx_pkg::CMD_PRELOAD, 32'h0, 16'hFFFE, 8'h7F});
    issue_ins({20'hFFFFF, 5'd1, rvx_pkg::OP_LUI});
    issue_ins(enc_i(12'h800, 5'd0, rvx_pkg::F3_ADD, 5'd2, rvx_pkg::OP_IMM));
    issue_ins(enc_i(12'h7FF, 5'd0, rvx_pkg::F3_ADD, 5'd3, rvx_pkg::OP_IMM));
    issue_ins(enc_r(rvx_pkg::F7_ALT, 5'd3, 5'd2, rvx_pkg::F3_ADD, 5'd4, rvx_pkg::OP_REG));
    issue_ins(enc_r(rvx_pkg::F7_ALT, 5'd3, 5'd1, rvx_pkg::F3_SR, 5'd5, rvx_pkg::OP_REG));
    issue_ins(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_SLT, 5'd6, rvx_pkg::OP_REG));
    issue_ins(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_SLTU, 5'd7, rvx_pkg::OP_REG));
    issue_ins(enc_b(13'h010, 5'd3, 5'd1, rvx_pkg::F3_BLT));
    issue_ins(enc_i(12'h003, 5'd3, 3'd0, 5'd8, rvx_pkg::OP_JALR));
    issue_ins(enc_i(12'hFFF, 5'd0, rvx_pkg::F3_H, 5'd9, rvx_pkg::OP_LOAD));
    issue_ins(enc_i(12'h000, 5'd0, rvx_pkg::F3_W, 5'd10, rvx_pkg::OP_LOAD));
    issue_ins(enc_i(12'h000, 5'd0, rvx_pkg::F3_B, 5'd0, rvx_pkg::OP_LOAD));
    issue_ins(enc_r(7'h01, 5'd3, 5'd2, rvx_pkg::F3_ADD, 5'd11, rvx_pkg::OP_REG));
    issue_ins(enc_i({7'h7F, 5'd3}, 5'd1, rvx_pkg::F3_SR, 5'd11, rvx_pkg::OP_IMM));
    issue_ins(enc_b(13'h020, 5'd1, 5'd1, 3'd2));
    issue_ins(enc_s(12'h10, 5'd1, 5'd0, 3'd3));
    issue_ins(enc_i(12'h0, 5'd0, 3'd6, 5'd12, rvx_pkg::OP_LOAD));
    issue_ins(32'hFFFF_FFFF);
    gen_console_store();
  endtask

  task automatic write_console(input logic [31:0] v);
    wait (instr_q.size() == 0 && retire_q.size() == 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    console_addr = v;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        void'(instr_q.pop_front());
        in_gap = pick_gap(in_calm);
        if ($urandom_range(0, 49) == 0) in_calm = ~in_calm;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0 || instr_q.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid           <= 1'b1;
          in_cmd             <= instr_q[0].cmd;
          in_instruction     <= instr_q[0].instruction;
          in_preload_address <= instr_q[0].paddr;
          in_preload_byte    <= instr_q[0].pbyte;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    retire_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (retire_q.size() == 0) begin
          report_mismatch("unexpected transfer", out_next_pc, '0);
        end else begin
          want = retire_q.pop_front();
          if (out_next_pc !== want.next_pc)
            report_mismatch("next_pc", out_next_pc, want.next_pc);
          if (out_illegal !== want.illegal)
            report_mismatch("illegal", 32'(out_illegal), 32'(want.illegal));
          if (out_rd_write_valid !== want.rd_wr)
            report_mismatch("rd_write_valid", 32'(out_rd_write_valid), 32'(want.rd_wr));
          if (out_rd_index !== want.rd_idx)
            report_mismatch("rd_index", 32'(out_rd_index), 32'(want.rd_idx));
          if (out_rd_value !== want.rd_val)
            report_mismatch("rd_value", out_rd_value, want.rd_val);
          if (out_console_valid !== want.con_valid)
            report_mismatch("console_valid", 32'(out_console_valid), 32'(want.con_valid));
          if (out_console_char !== want.con_char)
            report_mismatch("console_char", 32'(out_console_char), 32'(want.con_char));
        end
        out_gap = pick_gap(out_calm);
        if ($urandom_range(0, 49) == 0) out_calm = ~out_calm;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [31:0] settings [5];
    settings = '{rvx_pkg::CONSOLE_RST, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0010,
                 32'($urandom)};
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_pc = '0;
    console_addr = rvx_pkg::CONSOLE_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    for (int p = 0; p < 5; p++) begin
      write_console(settings[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) gen_one();
    end
    wait (instr_q.size() == 0 && retire_q.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
